FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file of this core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the cycle after ante, outside reset.
`define SVM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check cons in the same cycle as ante, outside reset.
`define SVM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after reset is seen.
`define SVM_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Types, codes and constants of the sample voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

   localparam int VOICES_DEF       = 16;
   localparam int SAMPLE_DEPTH_DEF = 65536;
   localparam int BLOCK_FRAMES_DEF = 64;

   localparam int DVD_W = 18;   // divider dividend width
   localparam int DVS_W = 21;   // divider divisor width

   localparam logic [15:0] VOL_ONE = 16'h8000;
   localparam int MIX_MAX = 1048575;
   localparam int MIX_MIN = -1048576;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_PLAY   = 2'd1,
      OP_RENDER = 2'd2,
      OP_VOLUME = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_VOICE   = 2'd1,
      STAT_BAD_HANDLE = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WR_ST,
      ST_PLAY_POP,
      ST_PLAY_STK,
      ST_PLAY_GEN,
      ST_PLAY_WR,
      ST_VOL_RD,
      ST_VOL_CHK,
      ST_RND_VSEL,
      ST_RND_VLOAD,
      ST_RND_RDIV,
      ST_RND_FRD,
      ST_RND_FMUL,
      ST_RND_FACC,
      ST_RND_VUPD,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic        looping;
      logic [15:0] gen;
      logic [15:0] prev;
      logic [15:0] tgt;
      logic [16:0] pos;
      logic [16:0] len;
      logic [15:0] start;
   } voice_rec_type;

   localparam int REC_W = $bits(voice_rec_type);

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quot;
      logic [DVS_W-1:0] rem;
   } div_rsp_type;

endpackage

FILE: rtl/core/svm_ram.sv
// ----------------------------------------------------------------------------
// svm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/core/svm_div.sv
// ----------------------------------------------------------------------------
// svm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  svm_pkg::div_req_type div_req,
   output svm_pkg::div_rsp_type div_rsp
);

   localparam int CW = $clog2(svm_pkg::DVD_W);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [svm_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [svm_pkg::DVD_W-1:0] quo_ff, quo_in;
   logic [svm_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [svm_pkg::DVS_W:0]   trial;
   logic                      ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[svm_pkg::DVD_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? svm_pkg::DVS_W'(trial - {1'b0, dvs_ff})
                     : svm_pkg::DVS_W'(trial);
         quo_in = {quo_ff[svm_pkg::DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(svm_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

FILE: rtl/core/sample_voice_mixer_core.sv
// A render walks every used slot, then sends one beat per frame out;
//   output stalls add to its time.
// Throughput: one item at a time; the shared divider and the read-multiply-accumulate
//   loop per frame set the render time.
// Reset: synchronous, active high; clears the sequencer, voice counts, playing
//   bits and the output beat; the sample memory and voice records are not cleared.
// ----------------------------------------------------------------------------
// sample_voice_mixer_core
// Multi-voice sample playback mixer with a sequencer over one shared divider
// and one multiplier.
// ----------------------------------------------------------------------------
module sample_voice_mixer_core #(
   parameter int VOICES       = svm_pkg::VOICES_DEF,
   parameter int SAMPLE_DEPTH = svm_pkg::SAMPLE_DEPTH_DEF,
   parameter int BLOCK_FRAMES = svm_pkg::BLOCK_FRAMES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sample_address[15:0], sample_value[31:16], clip_start[47:32],
   // clip_length[64:48], volume[80:65], loop_flag[81], frame_count[88:82],
   // handle_index[92:89], handle_generation[108:93], zero fill
   input  logic [111:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // mix_sample[20:0], status[22:21], voice_index[26:23],
   // voice_generation[42:27], zero fill
   output logic [47:0]  rsp_tdata,
   output logic         rsp_tlast
);

   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CNT_W  = $clog2(VOICES + 1);
   localparam int SA_W   = $clog2(SAMPLE_DEPTH);
   localparam int FA_W   = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
   localparam int FC_W   = $clog2(BLOCK_FRAMES + 1);
   localparam int ACC_W  = 19 + VIDX_W;
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(svm_pkg::MIX_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(svm_pkg::MIX_MIN);

   // Request field view
   logic [15:0] f_saddr, f_sval, f_cstart, f_vol, f_hgen;
   logic [16:0] f_clen;
   logic        f_loop;
   logic [6:0]  f_fcount;
   logic [3:0]  f_hidx;

   assign f_saddr  = req_tdata[15:0];
   assign f_sval   = req_tdata[31:16];
   assign f_cstart = req_tdata[47:32];
   assign f_clen   = req_tdata[64:48];
   assign f_vol    = req_tdata[80:65];
   assign f_loop   = req_tdata[81];
   assign f_fcount = req_tdata[88:82];
   assign f_hidx   = req_tdata[92:89];
   assign f_hgen   = req_tdata[108:93];

   svm_pkg::state_type state_ff, state_in;

   // Latched request
   logic [15:0]       sa_ff, sa_in, sv_ff, sv_in, cs_ff, cs_in;
   logic [15:0]       tvol_ff, tvol_in, hgen_ff, hgen_in;
   logic [16:0]       cl_ff, cl_in;
   logic              loop_ff, loop_in;
   logic [FC_W-1:0]   frames_ff, frames_in;
   logic [3:0]        hidx_ff, hidx_in;

   // Voice bookkeeping
   logic [CNT_W-1:0]  slots_ff, slots_in, fcnt_ff, fcnt_in, v_ff, v_in;
   logic [VOICES-1:0] playing_ff, playing_in;
   logic [VIDX_W-1:0] slot_ff, slot_in;
   logic [15:0]       gen_ff, gen_in;

   // Render datapath
   logic [FC_W-1:0]   n_ff, n_in, i_ff, i_in, j_ff, j_in, rd_ff, rd_in, r_ff, r_in;
   logic              neg_ff, neg_in;
   logic [15:0]       qd_ff, qd_in, q_ff, q_in, volr_ff, volr_in;
   logic [SA_W-1:0]   addr_ff, addr_in;
   logic signed [32:0] prod_ff, prod_in;
   logic [BLOCK_FRAMES-1:0] accv_ff, accv_in;

   // Output beat
   logic              rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [20:0]       rsp_mix_ff, rsp_mix_in;
   svm_pkg::status_type rsp_stat_ff, rsp_stat_in;
   logic [3:0]        rsp_idx_ff, rsp_idx_in;
   logic [15:0]       rsp_gen_ff, rsp_gen_in;

   // Memory ports
   logic              sm_wr_en, sm_rd_en;
   logic [SA_W-1:0]   sm_wr_addr, sm_rd_addr;
   logic [15:0]       sm_wr_data, sm_rd_data;
   logic              rec_wr_en, rec_rd_en;
   logic [VIDX_W-1:0] rec_wr_addr, rec_rd_addr;
   logic [svm_pkg::REC_W-1:0] rec_wr_data, rec_rd_data;
   logic              stk_wr_en, stk_rd_en;
   logic [VIDX_W-1:0] stk_wr_addr, stk_rd_addr, stk_wr_data, stk_rd_data;
   logic              acc_wr_en, acc_rd_en;
   logic [FA_W-1:0]   acc_wr_addr, acc_rd_addr;
   logic [ACC_W-1:0]  acc_wr_data, acc_rd_data;

   svm_pkg::div_req_type div_req;
   svm_pkg::div_rsp_type div_rsp;

   svm_pkg::voice_rec_type rec_q, rec_w;
   assign rec_q = svm_pkg::voice_rec_type'(rec_rd_data);

   // Scratch values of the sequencer
   logic              req_fire, rsp_fire;
   logic [15:0]       vol_sat;
   logic [FC_W-1:0]   fr_clamp;
   logic [16:0]       clen_left;
   logic [16:0]       dsum;
   logic [FC_W:0]     r_sum;
   logic [16:0]       vol_next;
   logic signed [17:0] term;
   logic signed [ACC_W-1:0] acc_old, acc_sum;
   logic [17:0]       pos_sum;
   logic              ended;
   logic [SA_W:0]     addr_inc;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_valid_ff && rsp_tready;

   // Volume above unity clamps to unity; frame count clamps to 1..BLOCK_FRAMES.
   assign vol_sat = (f_vol > svm_pkg::VOL_ONE) ? svm_pkg::VOL_ONE : f_vol;
   always_comb begin
      if (f_fcount == 7'd0) begin
         fr_clamp = FC_W'(1);
      end else if (f_fcount > 7'(BLOCK_FRAMES)) begin
         fr_clamp = FC_W'(BLOCK_FRAMES);
      end else begin
         fr_clamp = FC_W'(f_fcount);
      end
   end

   assign req_tready = (state_ff == svm_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      sa_in        = sa_ff;
      sv_in        = sv_ff;
      cs_in        = cs_ff;
      cl_in        = cl_ff;
      tvol_in      = tvol_ff;
      loop_in      = loop_ff;
      frames_in    = frames_ff;
      hidx_in      = hidx_ff;
      hgen_in      = hgen_ff;
      slots_in     = slots_ff;
      fcnt_in      = fcnt_ff;
      v_in         = v_ff;
      playing_in   = playing_ff;
      slot_in      = slot_ff;
      gen_in       = gen_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rd_in        = rd_ff;
      r_in         = r_ff;
      neg_in       = neg_ff;
      qd_in        = qd_ff;
      q_in         = q_ff;
      volr_in      = volr_ff;
      addr_in      = addr_ff;
      prod_in      = prod_ff;
      accv_in      = accv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_mix_in   = rsp_mix_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_gen_in   = rsp_gen_ff;

      clen_left = rec_q.len - rec_q.pos;
      dsum      = {1'b0, rec_q.tgt} - {1'b0, rec_q.prev};
      r_sum     = {1'b0, r_ff} + {1'b0, rd_ff};
      vol_next  = neg_ff ? ({1'b0, rec_q.prev} - {1'b0, q_ff})
                         : ({1'b0, rec_q.prev} + {1'b0, q_ff});
      // Arithmetic shift floors the scaled product for both signs.
      term      = prod_ff[32:15];
      acc_old   = accv_ff[i_ff[FA_W-1:0]] ? $signed(acc_rd_data) : '0;
      acc_sum   = acc_old + ACC_W'(term);
      pos_sum   = 18'(rec_q.pos) + 18'(frames_ff);
      ended     = pos_sum >= 18'(rec_q.len);
      addr_inc  = {1'b0, addr_ff} + 1'b1;

      sm_wr_en    = 1'b0;
      sm_wr_addr  = '0;
      sm_wr_data  = sv_ff;
      sm_rd_en    = 1'b0;
      sm_rd_addr  = addr_ff;
      rec_wr_en   = 1'b0;
      rec_wr_addr = slot_ff;
      rec_rd_en   = 1'b0;
      rec_rd_addr = v_ff[VIDX_W-1:0];
      stk_wr_en   = 1'b0;
      stk_wr_addr = VIDX_W'(fcnt_ff);
      stk_wr_data = v_ff[VIDX_W-1:0];
      stk_rd_en   = 1'b0;
      stk_rd_addr = VIDX_W'(fcnt_ff - 1'b1);
      acc_wr_en   = 1'b0;
      acc_wr_addr = i_ff[FA_W-1:0];
      acc_wr_data = acc_sum;
      acc_rd_en   = 1'b0;
      acc_rd_addr = i_ff[FA_W-1:0];
      div_req     = '0;
      rec_w       = rec_q;

      case (state_ff)
         svm_pkg::ST_IDLE: begin
            if (req_fire) begin
               sa_in     = f_saddr;
               sv_in     = f_sval;
               cs_in     = f_cstart;
               cl_in     = f_clen;
               tvol_in   = vol_sat;
               loop_in   = f_loop;
               frames_in = fr_clamp;
               hidx_in   = f_hidx;
               hgen_in   = f_hgen;
               case (svm_pkg::opcode_type'(req_tuser))
                  svm_pkg::OP_WRITE:  state_in = svm_pkg::ST_WR_ST;
                  svm_pkg::OP_PLAY:   state_in = svm_pkg::ST_PLAY_POP;
                  svm_pkg::OP_RENDER: begin
                     // Drop all partial sums of the previous render.
                     accv_in  = '0;
                     v_in     = '0;
                     state_in = svm_pkg::ST_RND_VSEL;
                  end
                  svm_pkg::OP_VOLUME: state_in = svm_pkg::ST_VOL_RD;
                  default:            state_in = svm_pkg::ST_IDLE;
               endcase
            end
         end

         // Sample write: the address wraps at the memory depth.
         svm_pkg::ST_WR_ST: begin
            sm_wr_en     = 1'b1;
            sm_wr_addr   = SA_W'(sa_ff);
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_mix_in   = '0;
            rsp_stat_in  = svm_pkg::STAT_OK;
            rsp_idx_in   = '0;
            rsp_gen_in   = '0;
            state_in     = svm_pkg::ST_SEND;
         end

         // Play: pop a freed slot first, else take the next fresh one.
         svm_pkg::ST_PLAY_POP: begin
            if (fcnt_ff != '0) begin
               stk_rd_en = 1'b1;
               fcnt_in   = fcnt_ff - 1'b1;
               state_in  = svm_pkg::ST_PLAY_STK;
            end else if (slots_ff < CNT_W'(VOICES)) begin
               slot_in  = VIDX_W'(slots_ff);
               gen_in   = 16'd1;
               slots_in = slots_ff + 1'b1;
               state_in = svm_pkg::ST_PLAY_WR;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_mix_in   = '0;
               rsp_stat_in  = svm_pkg::STAT_NO_VOICE;
               rsp_idx_in   = '0;
               rsp_gen_in   = '0;
               state_in     = svm_pkg::ST_SEND;
            end
         end

         svm_pkg::ST_PLAY_STK: begin
            slot_in     = stk_rd_data;
            rec_rd_en   = 1'b1;
            rec_rd_addr = stk_rd_data;
            state_in    = svm_pkg::ST_PLAY_GEN;
         end

         // A reused slot keeps its generation.
         svm_pkg::ST_PLAY_GEN: begin
            gen_in   = rec_q.gen;
            state_in = svm_pkg::ST_PLAY_WR;
         end

         svm_pkg::ST_PLAY_WR: begin
            rec_w.looping = loop_ff;
            rec_w.gen     = gen_ff;
            rec_w.prev    = '0;
            rec_w.tgt     = tvol_ff;
            rec_w.pos     = '0;
            rec_w.len     = cl_ff;
            rec_w.start   = cs_ff;
            rec_wr_en     = 1'b1;
            rec_wr_addr   = slot_ff;
            playing_in[slot_ff] = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_mix_in    = '0;
            rsp_stat_in   = svm_pkg::STAT_OK;
            rsp_idx_in    = 4'(slot_ff);
            rsp_gen_in    = gen_ff;
            state_in      = svm_pkg::ST_SEND;
         end

         // Volume: the handle must name a used slot of the same generation.
         svm_pkg::ST_VOL_RD: begin
            if (8'(hidx_ff) >= 8'(slots_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_mix_in   = '0;
               rsp_stat_in  = svm_pkg::STAT_BAD_HANDLE;
               rsp_idx_in   = '0;
               rsp_gen_in   = '0;
               state_in     = svm_pkg::ST_SEND;
            end else begin
               rec_rd_en   = 1'b1;
               rec_rd_addr = VIDX_W'(hidx_ff);
               state_in    = svm_pkg::ST_VOL_CHK;
            end
         end

         svm_pkg::ST_VOL_CHK: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_mix_in   = '0;
            rsp_idx_in   = '0;
            rsp_gen_in   = '0;
            if (rec_q.gen != hgen_ff) begin
               rsp_stat_in = svm_pkg::STAT_BAD_HANDLE;
            end else begin
               rsp_stat_in = svm_pkg::STAT_OK;
               rec_w.tgt   = tvol_ff;
               rec_wr_en   = 1'b1;
               rec_wr_addr = VIDX_W'(hidx_ff);
            end
            state_in = svm_pkg::ST_SEND;
         end

         // Render: walk the used slots in order, skipping idle ones.
         svm_pkg::ST_RND_VSEL: begin
            if (v_ff >= slots_ff) begin
               j_in     = '0;
               state_in = svm_pkg::ST_OUT_RD;
            end else if (playing_ff[v_ff[VIDX_W-1:0]]) begin
               rec_rd_en = 1'b1;
               state_in  = svm_pkg::ST_RND_VLOAD;
            end else begin
               v_in = v_ff + 1'b1;
            end
         end

         // Frames this voice covers: the rest of the clip, capped by the block.
         svm_pkg::ST_RND_VLOAD: begin
            if (rec_q.pos >= rec_q.len) begin
               n_in = '0;
            end else if (clen_left < 17'(frames_ff)) begin
               n_in = FC_W'(clen_left);
            end else begin
               n_in = frames_ff;
            end
            neg_in = dsum[16];
            if ((rec_q.pos >= rec_q.len) || (rec_q.len == '0)) begin
               state_in = svm_pkg::ST_RND_VUPD;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = svm_pkg::DVD_W'(dsum[16] ? 17'(-dsum) : dsum);
               div_req.divisor  = (clen_left < 17'(frames_ff))
                                  ? svm_pkg::DVS_W'(clen_left)
                                  : svm_pkg::DVS_W'(frames_ff);
               state_in         = svm_pkg::ST_RND_RDIV;
            end
         end

         // Ramp step = |diff| / n as quotient plus remainder; the first sample
         // address wraps at the memory depth.
         svm_pkg::ST_RND_RDIV: begin
            if (div_rsp.done) begin
               qd_in    = div_rsp.quot[15:0];
               rd_in    = div_rsp.rem[FC_W-1:0];
               q_in     = '0;
               r_in     = '0;
               i_in     = '0;
               addr_in  = SA_W'(18'(rec_q.start) + 18'(rec_q.pos));
               state_in = svm_pkg::ST_RND_FRD;
            end
         end

         svm_pkg::ST_RND_FRD: begin
            sm_rd_en  = 1'b1;
            acc_rd_en = 1'b1;
            volr_in   = vol_next[15:0];
            state_in  = svm_pkg::ST_RND_FMUL;
         end

         svm_pkg::ST_RND_FMUL: begin
            prod_in  = $signed(sm_rd_data) * $signed({1'b0, volr_ff});
            state_in = svm_pkg::ST_RND_FACC;
         end

         svm_pkg::ST_RND_FACC: begin
            acc_wr_en   = 1'b1;
            acc_wr_data = acc_sum;
            accv_in[i_ff[FA_W-1:0]] = 1'b1;
            // Advance the ramp by one exact step.
            if (r_sum >= {1'b0, n_ff}) begin
               r_in = FC_W'(r_sum - {1'b0, n_ff});
               q_in = q_ff + qd_ff + 1'b1;
            end else begin
               r_in = FC_W'(r_sum);
               q_in = q_ff + qd_ff;
            end
            addr_in = (addr_inc == (SA_W + 1)'(SAMPLE_DEPTH)) ? '0 : addr_inc[SA_W-1:0];
            i_in    = i_ff + 1'b1;
            if (FC_W'(i_ff + 1'b1) == n_ff) begin
               state_in = svm_pkg::ST_RND_VUPD;
            end else begin
               state_in = svm_pkg::ST_RND_FRD;
            end
         end

         // End of block: settle the volume, move the position, loop or free.
         svm_pkg::ST_RND_VUPD: begin
            rec_w.prev  = rec_q.tgt;
            rec_w.pos   = pos_sum[16:0];
            rec_wr_en   = 1'b1;
            rec_wr_addr = v_ff[VIDX_W-1:0];
            if (ended) begin
               if (rec_q.looping) begin
                  rec_w.pos = '0;
               end else begin
                  playing_in[v_ff[VIDX_W-1:0]] = 1'b0;
                  rec_w.gen = rec_q.gen + 1'b1;
                  if (fcnt_ff < CNT_W'(VOICES)) begin
                     stk_wr_en = 1'b1;
                     fcnt_in   = fcnt_ff + 1'b1;
                  end
               end
            end
            v_in     = v_ff + 1'b1;
            state_in = svm_pkg::ST_RND_VSEL;
         end

         svm_pkg::ST_OUT_RD: begin
            acc_rd_en   = 1'b1;
            acc_rd_addr = j_ff[FA_W-1:0];
            state_in    = svm_pkg::ST_OUT_LD;
         end

         // Saturate the frame sum to the output range.
         svm_pkg::ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = (FC_W'(j_ff + 1'b1) == frames_ff);
            rsp_stat_in  = svm_pkg::STAT_OK;
            rsp_idx_in   = '0;
            rsp_gen_in   = '0;
            if (!accv_ff[j_ff[FA_W-1:0]]) begin
               rsp_mix_in = '0;
            end else if ($signed(acc_rd_data) > ACC_MAX) begin
               rsp_mix_in = 21'(ACC_MAX);
            end else if ($signed(acc_rd_data) < ACC_MIN) begin
               rsp_mix_in = 21'(ACC_MIN);
            end else begin
               rsp_mix_in = acc_rd_data[20:0];
            end
            state_in = svm_pkg::ST_SEND;
         end

         // Hold the beat until taken.
         svm_pkg::ST_SEND: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = svm_pkg::ST_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = svm_pkg::ST_OUT_RD;
               end
            end
         end

         default: state_in = svm_pkg::ST_IDLE;
      endcase

      rec_wr_data = rec_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svm_pkg::ST_IDLE;
         slots_ff     <= '0;
         fcnt_ff      <= '0;
         playing_ff   <= '0;
         accv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slots_ff     <= slots_in;
         fcnt_ff      <= fcnt_in;
         playing_ff   <= playing_in;
         accv_ff      <= accv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sa_ff       <= sa_in;
      sv_ff       <= sv_in;
      cs_ff       <= cs_in;
      cl_ff       <= cl_in;
      tvol_ff     <= tvol_in;
      loop_ff     <= loop_in;
      frames_ff   <= frames_in;
      hidx_ff     <= hidx_in;
      hgen_ff     <= hgen_in;
      v_ff        <= v_in;
      slot_ff     <= slot_in;
      gen_ff      <= gen_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      rd_ff       <= rd_in;
      r_ff        <= r_in;
      neg_ff      <= neg_in;
      qd_ff       <= qd_in;
      q_ff        <= q_in;
      volr_ff     <= volr_in;
      addr_ff     <= addr_in;
      prod_ff     <= prod_in;
      rsp_last_ff <= rsp_last_in;
      rsp_mix_ff  <= rsp_mix_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_gen_ff  <= rsp_gen_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_gen_ff, rsp_idx_ff, rsp_stat_ff, rsp_mix_ff};

   svm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   svm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
      .clock   (clock),
      .wr_en   (sm_wr_en),
      .wr_addr (sm_wr_addr),
      .wr_data (sm_wr_data),
      .rd_en   (sm_rd_en),
      .rd_addr (sm_rd_addr),
      .rd_data (sm_rd_data)
   );

   svm_ram #(.WIDTH(svm_pkg::REC_W), .DEPTH(VOICES)) u_voice_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_en   (rec_rd_en),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   svm_ram #(.WIDTH(VIDX_W), .DEPTH(VOICES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   svm_ram #(.WIDTH(ACC_W), .DEPTH(BLOCK_FRAMES)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_en   (acc_rd_en),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

endmodule

FILE: rtl/core/svm_checker.sv
// ----------------------------------------------------------------------------
// svm_checker
// Port-level checks of the mixer core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   `SVM_ASSERT_SAME(a_idle_no_beat, req_tready, !rsp_tvalid, "ready while a beat is pending")
   `SVM_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready after accept")
   `SVM_ASSERT_RESET(a_reset_idle, req_tready && !rsp_tvalid, "not idle after reset")
   `SVM_ASSERT_NEXT(a_last_ends, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid, "beat after last")
   `SVM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled beat changed")

endmodule

bind sample_voice_mixer_core svm_checker u_svm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
